// ===== sv/pga_pkg.sv =====
// ----------------------------------------------------------------------------
// pga_pkg
// Shared types, codes and constants of the planar gravity accumulator.
// ----------------------------------------------------------------------------
package pga_pkg;

   localparam int PGA_MAX_PLANETS = 16;

   localparam int POS_W   = 24;
   localparam int COEF_W  = 24;
   localparam int ACCEL_W = 32;
   localparam int COUNT_W = 5;

   localparam int MAG_W  = POS_W + 1;
   localparam int PROD_W = 2 * MAG_W;
   localparam int QUOT_W = 32;

   localparam logic [PROD_W-1:0] DD_ONE = PROD_W'(65536);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [3:0]               entry_index;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [COEF_W-1:0]        coefficient;
   } pga_req_type;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
   } pga_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_MUL_XX,
      ST_MUL_YY,
      ST_MUL_XC,
      ST_MUL_YC,
      ST_CHECK,
      ST_DIV_X,
      ST_ACC_X,
      ST_DIV_Y,
      ST_ACC_Y,
      ST_FINISH
   } pga_state_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== sv/pga_ram.sv =====
// ----------------------------------------------------------------------------
// pga_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pga_ram
   import pga_pkg::*;
#(
   parameter int WIDTH = 48,
   parameter int DEPTH = PGA_MAX_PLANETS
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [addr_width(DEPTH)-1:0]  waddr,
   input  logic [WIDTH-1:0]              wdata,
   input  logic [addr_width(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/planar_gravity_accumulator.sv =====
// ----------------------------------------------------------------------------
// planar_gravity_accumulator
// Sums the pull of a table of planets on an object and returns the
// negated, saturated 2-D acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on req_data when start is high and busy is low.
//   req_type load writes entry entry_index of the planet table in that
//   cycle; busy stays low and no result follows. req_type query latches
//   the object position and coefficient and raises busy.
//   The query walks the first planet_count entries (at most MAX_PLANETS)
//   using one multiplier and one restoring divider: an entry more than one
//   pixel away takes a read, 4 multiplies, two 32-step divisions and
//   bookkeeping; an entry within one pixel is dropped after its multiplies.
//   The result word appears on rsp_data with rsp_valid high for one cycle;
//   busy is low in that cycle, so the next word may be taken there.
//   planet_count is written through csr_we/csr_wdata; write it only while
//   idle, the block itself does not enforce this.
//   Reset clears planet_count and the sequencer; the table is not cleared
//   and must be loaded before it is queried. The receiver cannot stall.
// ----------------------------------------------------------------------------
module planar_gravity_accumulator
   import pga_pkg::*;
#(
   parameter int MAX_PLANETS = PGA_MAX_PLANETS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pga_req_type         req_data,
   output logic                rsp_valid,
   output pga_rsp_type         rsp_data,
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_wdata
);

   localparam int AddrW = addr_width(MAX_PLANETS);
   localparam int CntW  = $clog2(MAX_PLANETS + 1);
   localparam int SumW  = QUOT_W + 1 + CntW;
   localparam int RamW  = 2 * POS_W;

   pga_state_type state_ff, state_in;

   logic [COUNT_W-1:0]       planet_count_ff;
   logic [CntW-1:0]          cnt_lim;
   logic [CntW-1:0]          n_ff;
   logic [CntW-1:0]          idx_ff;
   logic [CntW:0]            idx_next;

   logic signed [POS_W-1:0]  ox_ff, oy_ff;
   logic [COEF_W-1:0]        coef_ff;

   logic                     load_we;
   logic [AddrW-1:0]         load_addr;
   logic [RamW-1:0]          ram_rdata;
   logic signed [POS_W-1:0]  px, py;
   logic signed [MAG_W-1:0]  rx, ry;

   logic [MAG_W-1:0]         ax_ff, ay_ff;
   logic                     sx_ff, sy_ff;
   logic [MAG_W-1:0]         mul_a, mul_b;
   logic [PROD_W-1:0]        prod;
   logic [PROD_W-1:0]        dd_ff, numx_ff, numy_ff;

   logic [PROD_W-1:0]        rem_ff;
   logic [QUOT_W-1:0]        shreg_ff;
   logic [4:0]               div_cnt_ff;
   logic [PROD_W:0]          rem_sh;
   logic                     rem_ge;
   logic [PROD_W-1:0]        rem_in;

   logic signed [SumW-1:0]   sum_ff;
   logic signed [SumW-1:0]   term;
   logic signed [SumW-1:0]   neg_sum;
   logic                     sum_fits;
   logic [ACCEL_W-1:0]       sat_x, sat_y;
   logic                     rsp_valid_ff;
   pga_rsp_type              rsp_data_ff;

   // planet table, x in the upper half

   assign load_we   = start && !busy && (req_data.req_type == REQ_LOAD)
                      && (32'(req_data.entry_index) < 32'(MAX_PLANETS));
   assign load_addr = AddrW'(req_data.entry_index);

   pga_ram #(
      .WIDTH (RamW),
      .DEPTH (MAX_PLANETS)
   ) u_table (
      .clock (clock),
      .we    (load_we),
      .waddr (load_addr),
      .wdata ({req_data.pos_x, req_data.pos_y}),
      .raddr (idx_ff[AddrW-1:0]),
      .rdata (ram_rdata)
   );

   assign px = ram_rdata[RamW-1:POS_W];
   assign py = ram_rdata[POS_W-1:0];
   assign rx = {ox_ff[POS_W-1], ox_ff} - {px[POS_W-1], px};
   assign ry = {oy_ff[POS_W-1], oy_ff} - {py[POS_W-1], py};

   assign cnt_lim = (32'(planet_count_ff) > 32'(MAX_PLANETS)) ?
                    CntW'(MAX_PLANETS) : CntW'(planet_count_ff);
   assign idx_next = {1'b0, idx_ff} + (CntW+1)'(1);

   // shared multiplier and divider step

   assign prod = mul_a * mul_b;

   assign rem_sh = {rem_ff, shreg_ff[QUOT_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, dd_ff});
   assign rem_in = rem_ge ? PROD_W'(rem_sh - {1'b0, dd_ff}) : rem_sh[PROD_W-1:0];

   always_comb begin
      term = SumW'({1'b0, shreg_ff});
      if ((state_ff == ST_ACC_X) ? sx_ff : sy_ff) begin
         term = -term;
      end
   end

   assign neg_sum  = -sum_ff;
   assign sum_fits = (&neg_sum[SumW-1:ACCEL_W-1]) || !(|neg_sum[SumW-1:ACCEL_W-1]);

   // next state

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (req_data.req_type == REQ_QUERY)) begin
               state_in = (cnt_lim == '0) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL_XX;
         ST_MUL_XX: state_in = ST_MUL_YY;
         ST_MUL_YY: state_in = ST_MUL_XC;
         ST_MUL_XC: state_in = ST_MUL_YC;
         ST_MUL_YC: state_in = ST_CHECK;
         ST_CHECK: begin
            if (dd_ff > DD_ONE) begin
               state_in = ST_DIV_X;
            end else begin
               state_in = (idx_next < {1'b0, n_ff}) ? ST_READ : ST_FINISH;
            end
         end
         ST_DIV_X: begin
            if (div_cnt_ff == 5'd31) begin
               state_in = ST_ACC_X;
            end
         end
         ST_ACC_X:  state_in = ST_DIV_Y;
         ST_DIV_Y: begin
            if (div_cnt_ff == 5'd31) begin
               state_in = ST_ACC_Y;
            end
         end
         ST_ACC_Y: begin
            state_in = (idx_next < {1'b0, n_ff}) ? ST_READ : ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer

   always_comb begin
      busy  = (state_ff != ST_IDLE);
      mul_a = ax_ff;
      mul_b = ax_ff;
      case (state_ff)
         ST_MUL_XX: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         ST_MUL_YY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         ST_MUL_XC: begin
            mul_a = ax_ff;
            mul_b = MAG_W'(coef_ff);
         end
         ST_MUL_YC: begin
            mul_a = ay_ff;
            mul_b = MAG_W'(coef_ff);
         end
         default: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
      endcase
   end

   // control registers

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         planet_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_FINISH);
         if (csr_we) begin
            planet_count_ff <= csr_wdata;
         end
      end
   end

   // datapath registers

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ox_ff   <= req_data.pos_x;
            oy_ff   <= req_data.pos_y;
            coef_ff <= req_data.coefficient;
            n_ff    <= cnt_lim;
            idx_ff  <= '0;
            sum_ff  <= '0;
         end
         ST_DIFF: begin
            sx_ff <= rx[MAG_W-1];
            sy_ff <= ry[MAG_W-1];
            ax_ff <= rx[MAG_W-1] ? MAG_W'(-rx) : MAG_W'(rx);
            ay_ff <= ry[MAG_W-1] ? MAG_W'(-ry) : MAG_W'(ry);
         end
         ST_MUL_XX: dd_ff   <= prod;
         ST_MUL_YY: dd_ff   <= dd_ff + prod;
         ST_MUL_XC: numx_ff <= prod;
         ST_MUL_YC: numy_ff <= prod;
         ST_CHECK: begin
            rem_ff     <= PROD_W'(numx_ff[PROD_W-1:16]);
            shreg_ff   <= {numx_ff[15:0], 16'h0000};
            div_cnt_ff <= '0;
            if (!(dd_ff > DD_ONE)) begin
               idx_ff <= idx_next[CntW-1:0];
            end
         end
         ST_DIV_X, ST_DIV_Y: begin
            rem_ff     <= rem_in;
            shreg_ff   <= {shreg_ff[QUOT_W-2:0], rem_ge};
            div_cnt_ff <= div_cnt_ff + 5'd1;
         end
         ST_ACC_X: begin
            sum_ff     <= sum_ff + term;
            rem_ff     <= PROD_W'(numy_ff[PROD_W-1:16]);
            shreg_ff   <= {numy_ff[15:0], 16'h0000};
            div_cnt_ff <= '0;
         end
         ST_ACC_Y: begin
            idx_ff <= idx_next[CntW-1:0];
         end
         ST_FINISH: begin
            rsp_data_ff.accel_x <= sat_x;
            rsp_data_ff.accel_y <= sat_y;
         end
         default: begin
         end
      endcase
   end

   // y sum in its own register

   logic signed [SumW-1:0] sum_y_ff;
   logic signed [SumW-1:0] neg_sum_y;
   logic                   sum_y_fits;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         sum_y_ff <= '0;
      end else if (state_ff == ST_ACC_Y) begin
         sum_y_ff <= sum_y_ff + term;
      end
   end

   assign neg_sum_y  = -sum_y_ff;
   assign sum_y_fits = (&neg_sum_y[SumW-1:ACCEL_W-1])
                       || !(|neg_sum_y[SumW-1:ACCEL_W-1]);

   assign sat_x = sum_fits ? neg_sum[ACCEL_W-1:0] :
                  (neg_sum[SumW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
   assign sat_y = sum_y_fits ? neg_sum_y[ACCEL_W-1:0] :
                  (neg_sum_y[SumW-1] ? 32'h8000_0000 : 32'h7fff_ffff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_X && div_cnt_ff == 5'd31) |=> (state_ff == ST_ACC_X))
      else $error("x division did not end after 32 steps");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_X || state_ff == ST_DIV_Y) |-> (rem_ff < dd_ff))
      else $error("divider remainder not below divisor");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (idx_ff < n_ff))
      else $error("table walk beyond the active count");

endmodule
